>>> hw/rtl/gsi_pkg.sv
// ----------------------------------------------------------------------------
// Grass spread index package
// Shared types, fixed-point constants and constant tables of the grass spread
// index pipeline.
// ----------------------------------------------------------------------------
package gsi_pkg;

  localparam int unsigned LOG_STEPS = 16;
  localparam int unsigned POW_STEPS = 16;
  localparam int unsigned DIV_STEPS = 17;

  localparam logic [17:0] INDEX_MAX     = 18'd200000;
  localparam logic [10:0] WIND_KNEE     = 11'd50;
  localparam logic [10:0] WIND_BAND     = 11'd100;
  localparam logic [9:0]  MOIST_EXP_LIM = 10'd120;
  localparam logic [9:0]  MOIST_LO_LIM  = 10'd200;
  localparam logic [9:0]  MOIST_HI_LIM  = 10'd239;
  localparam logic [9:0]  CURE_MIN      = 10'd200;

  localparam logic [15:0] WIND_EXP_GAIN = 16'd55312;
  localparam logic [20:0] WIND_EXP_OFS  = 21'd183744;
  localparam logic [9:0]  CURE_EXP_GAIN = 10'd942;
  localparam logic [17:0] POW2_ONE      = 18'd65536;

  typedef struct packed {
    logic [10:0] wind;
    logic [9:0]  moist;
    logic [9:0]  cure;
  } gsi_ctx_t;

  localparam logic [16:0] POW2_TAB [16] = '{
    17'd92682, 17'd77936, 17'd71468, 17'd68438, 17'd66971, 17'd66250, 17'd65892, 17'd65714,
    17'd65625, 17'd65580, 17'd65558, 17'd65547, 17'd65542, 17'd65539, 17'd65537, 17'd65537
  };

  typedef logic [16:0] moist_tab_t [120];

  function automatic logic [17:0] pow2_frac_f(logic [15:0] g);
    longint unsigned acc;
    acc = 64'd65536;
    for (int k = 0; k < 16; k++) begin
      if (g[15-k]) begin
        acc = (acc * 64'(POW2_TAB[k]) + 64'd32768) >> 16;
      end
    end
    return 18'(acc);
  endfunction

  function automatic moist_tab_t build_moist_tab();
    moist_tab_t      tab;
    longint unsigned mag;
    longint unsigned q30;
    int unsigned     n;
    int unsigned     f;
    for (int i = 0; i < 120; i++) begin
      mag = 64'(i) * 64'd1021;
      n   = 32'(mag >> 16);
      f   = 32'(mag[15:0]);
      if (f == 0) begin
        q30 = (64'd1 << 30) >> n;
      end else begin
        q30 = (64'(pow2_frac_f(16'(32'd65536 - f))) << 14) >> (n + 1);
      end
      tab[i] = 17'((q30 + 64'd8192) >> 14);
    end
    return tab;
  endfunction

  localparam moist_tab_t MOIST_TAB = build_moist_tab();

endpackage

>>> hw/rtl/gsi_log2_pipe.sv
// ----------------------------------------------------------------------------
// Log2 pipeline
// Normalizes the wind excess and produces its base-2 logarithm in Q16, one
// fraction bit per squaring stage.
// ----------------------------------------------------------------------------
module gsi_log2_pipe import gsi_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        en_i,
  input  logic        valid_i,
  input  logic [10:0] d_i,
  input  gsi_ctx_t    ctx_i,
  output logic        valid_o,
  output logic [19:0] res_o,
  output gsi_ctx_t    ctx_o
);

  logic [3:0]  msb;
  logic [26:0] shifted;

  logic        vld_q  [LOG_STEPS+1];
  logic [16:0] x_q    [LOG_STEPS+1];
  logic [3:0]  int_q  [LOG_STEPS+1];
  logic [15:0] frac_q [LOG_STEPS+1];
  gsi_ctx_t    ctx_q  [LOG_STEPS+1];

  always_comb begin
    msb = '0;
    for (int b = 0; b < 11; b++) begin
      if (d_i[b]) begin
        msb = 4'(b);
      end
    end
  end

  assign shifted = {d_i, 16'b0} >> msb;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q[0] <= 1'b0;
    end else if (en_i) begin
      vld_q[0] <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x_q[0]    <= shifted[16:0];
      int_q[0]  <= msb;
      frac_q[0] <= '0;
      ctx_q[0]  <= ctx_i;
    end
  end

  for (genvar k = 1; k <= LOG_STEPS; k++) begin : g_sq
    logic [33:0] sq;
    logic [17:0] t;

    assign sq = {17'b0, x_q[k-1]} * {17'b0, x_q[k-1]};
    assign t  = sq[33:16];

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else if (en_i) begin
        vld_q[k] <= vld_q[k-1];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        x_q[k]    <= t[17] ? t[17:1] : t[16:0];
        int_q[k]  <= int_q[k-1];
        frac_q[k] <= frac_q[k-1] | ({15'b0, t[17]} << (LOG_STEPS - k));
        ctx_q[k]  <= ctx_q[k-1];
      end
    end
  end

  assign valid_o = vld_q[LOG_STEPS];
  assign res_o   = {int_q[LOG_STEPS], frac_q[LOG_STEPS]};
  assign ctx_o   = ctx_q[LOG_STEPS];

endmodule

>>> hw/rtl/gsi_exp_pipe.sv
// ----------------------------------------------------------------------------
// Exponential pipeline
// Forms the wind power exponent and the curing exponent, evaluates both
// powers of two in two lanes, and applies the integer shifts.
// ----------------------------------------------------------------------------
module gsi_exp_pipe import gsi_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        en_i,
  input  logic        valid_i,
  input  logic [19:0] res_i,
  input  gsi_ctx_t    ctx_i,
  output logic        valid_o,
  output logic [23:0] p_o,
  output logic [30:0] e_o,
  output gsi_ctx_t    ctx_o
);

  logic [35:0] ym_prod;
  logic [9:0]  c_off;
  logic [19:0] cm;

  logic        vld0_q;
  logic [19:0] ym_q;
  logic [19:0] cm_q;
  gsi_ctx_t    ctx0_q;

  logic [20:0] yw;
  logic        negw;
  logic [20:0] magw;
  logic [15:0] fw;
  logic [15:0] fc;

  logic        vld_q  [POW_STEPS+1];
  logic [17:0] accw_q [POW_STEPS+1];
  logic [17:0] accc_q [POW_STEPS+1];
  logic [15:0] gw_q   [POW_STEPS+1];
  logic [15:0] gc_q   [POW_STEPS+1];
  logic [4:0]  sw_q   [POW_STEPS+1];
  logic [4:0]  sc_q   [POW_STEPS+1];
  logic        negw_q [POW_STEPS+1];
  gsi_ctx_t    ctx_q  [POW_STEPS+1];

  logic [17:0] pfw;
  logic [17:0] pfc;
  logic [32:0] vw;
  logic [32:0] rw;
  logic [32:0] lw;
  logic [31:0] ec;
  logic [23:0] p_d;

  logic        vldf_q;
  logic [23:0] p_q;
  logic [30:0] e_q;
  gsi_ctx_t    ctxf_q;

  assign ym_prod = {16'b0, res_i} * {20'b0, WIND_EXP_GAIN} + 36'd32768;
  assign c_off   = (ctx_i.cure >= CURE_MIN) ? ctx_i.cure - CURE_MIN : '0;
  assign cm      = {10'b0, c_off} * {10'b0, CURE_EXP_GAIN};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld0_q <= 1'b0;
    end else if (en_i) begin
      vld0_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ym_q   <= ym_prod[35:16];
      cm_q   <= cm;
      ctx0_q <= ctx_i;
    end
  end

  assign yw   = {1'b0, ym_q} - WIND_EXP_OFS;
  assign negw = yw[20];
  assign magw = negw ? (~yw + 21'd1) : yw;
  assign fw   = magw[15:0];
  assign fc   = cm_q[15:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q[0] <= 1'b0;
    end else if (en_i) begin
      vld_q[0] <= vld0_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      accw_q[0] <= POW2_ONE;
      accc_q[0] <= POW2_ONE;
      gw_q[0]   <= negw ? (~fw + 16'd1) : fw;
      gc_q[0]   <= ~fc + 16'd1;
      sw_q[0]   <= {1'b0, magw[19:16]} + {4'b0, negw && (fw != '0)};
      sc_q[0]   <= {1'b0, cm_q[19:16]} + {4'b0, (fc != '0)};
      negw_q[0] <= negw;
      ctx_q[0]  <= ctx0_q;
    end
  end

  for (genvar k = 1; k <= POW_STEPS; k++) begin : g_pow
    logic [34:0] mw;
    logic [34:0] mc;

    assign mw = {17'b0, accw_q[k-1]} * {18'b0, POW2_TAB[k-1]} + 35'd32768;
    assign mc = {17'b0, accc_q[k-1]} * {18'b0, POW2_TAB[k-1]} + 35'd32768;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else if (en_i) begin
        vld_q[k] <= vld_q[k-1];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        accw_q[k] <= gw_q[k-1][POW_STEPS-k] ? mw[33:16] : accw_q[k-1];
        accc_q[k] <= gc_q[k-1][POW_STEPS-k] ? mc[33:16] : accc_q[k-1];
        gw_q[k]   <= gw_q[k-1];
        gc_q[k]   <= gc_q[k-1];
        sw_q[k]   <= sw_q[k-1];
        sc_q[k]   <= sc_q[k-1];
        negw_q[k] <= negw_q[k-1];
        ctx_q[k]  <= ctx_q[k-1];
      end
    end
  end

  assign pfw = accw_q[POW_STEPS];
  assign pfc = accc_q[POW_STEPS];
  assign vw  = {1'b0, pfw, 14'b0} >> sw_q[POW_STEPS];
  assign rw  = vw + 33'd8192;
  assign lw  = {15'b0, pfw} << sw_q[POW_STEPS];
  assign ec  = {pfc, 14'b0} >> sc_q[POW_STEPS];

  always_comb begin
    priority if (ctx_q[POW_STEPS].wind == WIND_KNEE) begin
      p_d = '0;
    end else if (negw_q[POW_STEPS]) begin
      p_d = 24'(rw[32:14]);
    end else begin
      p_d = lw[23:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vldf_q <= 1'b0;
    end else if (en_i) begin
      vldf_q <= vld_q[POW_STEPS];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p_q    <= p_d;
      e_q    <= ec[30:0];
      ctxf_q <= ctx_q[POW_STEPS];
    end
  end

  assign valid_o = vldf_q;
  assign p_o     = p_q;
  assign e_o     = e_q;
  assign ctx_o   = ctxf_q;

endmodule

>>> hw/rtl/gsi_rate_pipe.sv
// ----------------------------------------------------------------------------
// Rate pipeline
// Builds the wind and moisture factors, divides out the curing factor, forms
// both spread rates and the saturated index in hundredths.
// ----------------------------------------------------------------------------
module gsi_rate_pipe import gsi_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        en_i,
  input  logic        valid_i,
  input  logic [23:0] p_i,
  input  logic [30:0] e_i,
  input  gsi_ctx_t    ctx_i,
  output logic        valid_o,
  output logic [17:0] index_o,
  output logic        sat_o
);

  typedef struct packed {
    logic [27:0] fw_m;
    logic [27:0] fw_s;
    logic [16:0] fm;
    logic        cure;
  } rate_sb_t;

  logic [16:0] fm;
  logic [43:0] pm;
  logic [43:0] ps;
  logic [53:0] dp;
  logic [20:0] fwlo_m;
  logic [20:0] fwlo_s;

  logic        vld0_q;
  logic [43:0] pm_q;
  logic [43:0] ps_q;
  logic [53:0] dp_q;
  logic [20:0] fwlo_m_q;
  logic [20:0] fwlo_s_q;
  logic [16:0] fm_q;
  logic        wlow_q;
  logic        cure_q;

  logic [43:0] pmr;
  logic [43:0] psr;
  logic [54:0] dpr;
  logic [37:0] den;
  logic [47:0] num;
  rate_sb_t    sb;

  logic        vld_q [DIV_STEPS+1];
  logic [47:0] rem_q [DIV_STEPS+1];
  logic [37:0] den_q [DIV_STEPS+1];
  logic [16:0] quo_q [DIV_STEPS+1];
  rate_sb_t    sb_q  [DIV_STEPS+1];

  logic        vt_q [5];
  logic [16:0] cf0_q;
  logic [44:0] am0_q;
  logic [44:0] as0_q;
  logic [44:0] amr;
  logic [44:0] asr;
  logic [16:0] cf1_q;
  logic [28:0] am1_q;
  logic [28:0] as1_q;
  logic [45:0] bm2_q;
  logic [45:0] bs2_q;
  logic [45:0] bmr;
  logic [45:0] bsr;
  logic [30:0] sum_q;
  logic [39:0] tsum;
  logic [22:0] idx;
  logic [17:0] index_q;
  logic        sat_q;

  always_comb begin
    priority if (ctx_i.moist < MOIST_EXP_LIM) begin
      fm = MOIST_TAB[ctx_i.moist[6:0]];
    end else if (ctx_i.moist < MOIST_LO_LIM && ctx_i.wind < WIND_BAND) begin
      fm = 17'd44814 - 17'(ctx_i.moist) * 17'd224;
    end else if (ctx_i.moist < MOIST_HI_LIM && ctx_i.wind >= WIND_BAND) begin
      fm = 17'd35848 - 17'(ctx_i.moist) * 17'd149;
    end else begin
      fm = '0;
    end
  end

  assign pm     = {20'b0, p_i} * 44'd781127;
  assign ps     = {20'b0, p_i} * 44'd915503;
  assign dp     = {23'b0, e_i} * 54'd6815023;
  assign fwlo_m = 21'd58994 + 21'(ctx_i.wind[5:0]) * 21'd22833;
  assign fwlo_s = 21'd58994 + 21'(ctx_i.wind[5:0]) * 21'd29388;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld0_q <= 1'b0;
    end else if (en_i) begin
      vld0_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pm_q     <= pm;
      ps_q     <= ps;
      dp_q     <= dp;
      fwlo_m_q <= fwlo_m;
      fwlo_s_q <= fwlo_s;
      fm_q     <= fm;
      wlow_q   <= ctx_i.wind < WIND_KNEE;
      cure_q   <= ctx_i.cure >= CURE_MIN;
    end
  end

  assign pmr = pm_q + 44'd32768;
  assign psr = ps_q + 44'd32768;
  assign dpr = {1'b0, dp_q} + 55'd32768;
  assign den = (38'd1 << 30) + dpr[53:16];
  assign num = (48'd67895 << 30) + {11'b0, den[37:1]};

  always_comb begin
    sb.fw_m = wlow_q ? 28'(fwlo_m_q) : 28'd1201734 + pmr[43:16];
    sb.fw_s = wlow_q ? 28'(fwlo_s_q) : 28'd1529479 + psr[43:16];
    sb.fm   = fm_q;
    sb.cure = cure_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q[0] <= 1'b0;
    end else if (en_i) begin
      vld_q[0] <= vld0_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q[0] <= num;
      den_q[0] <= den;
      quo_q[0] <= '0;
      sb_q[0]  <= sb;
    end
  end

  for (genvar k = 1; k <= DIV_STEPS; k++) begin : g_div
    logic [53:0] trial;
    logic [53:0] rem_x;
    logic        ge;

    assign trial = {16'b0, den_q[k-1]} << (DIV_STEPS - k);
    assign rem_x = {6'b0, rem_q[k-1]};
    assign ge    = rem_x >= trial;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else if (en_i) begin
        vld_q[k] <= vld_q[k-1];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k] <= ge ? 48'(rem_x - trial) : rem_q[k-1];
        den_q[k] <= den_q[k-1];
        quo_q[k] <= quo_q[k-1] | ({16'b0, ge} << (DIV_STEPS - k));
        sb_q[k]  <= sb_q[k-1];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vt_q <= '{default: 1'b0};
    end else if (en_i) begin
      vt_q[0] <= vld_q[DIV_STEPS];
      for (int i = 1; i < 5; i++) begin
        vt_q[i] <= vt_q[i-1];
      end
    end
  end

  assign amr  = am0_q + 45'd32768;
  assign asr  = as0_q + 45'd32768;
  assign bmr  = bm2_q + 46'd32768;
  assign bsr  = bs2_q + 46'd32768;
  assign tsum = {9'b0, sum_q} * 40'd111 + 40'd65536;
  assign idx  = tsum[39:17];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      cf0_q   <= sb_q[DIV_STEPS].cure ? quo_q[DIV_STEPS] : '0;
      am0_q   <= {17'b0, sb_q[DIV_STEPS].fw_m} * {28'b0, sb_q[DIV_STEPS].fm};
      as0_q   <= {17'b0, sb_q[DIV_STEPS].fw_s} * {28'b0, sb_q[DIV_STEPS].fm};
      cf1_q   <= cf0_q;
      am1_q   <= amr[44:16];
      as1_q   <= asr[44:16];
      bm2_q   <= {17'b0, am1_q} * {29'b0, cf1_q};
      bs2_q   <= {17'b0, as1_q} * {29'b0, cf1_q};
      sum_q   <= {1'b0, bmr[45:16]} + {1'b0, bsr[45:16]};
      sat_q   <= idx > {5'b0, INDEX_MAX};
      index_q <= (idx > {5'b0, INDEX_MAX}) ? INDEX_MAX : idx[17:0];
    end
  end

  assign valid_o = vt_q[4];
  assign index_o = index_q;
  assign sat_o   = sat_q;

endmodule

>>> hw/rtl/grass_spread_index_calc_top.sv
// ----------------------------------------------------------------------------
// Grass spread index calculator
// Stateless pipeline: wind, moisture and curing in tenths in, grass spread
// index in hundredths out, saturated at its top.
//
//   Channel | Handshake                | Payload
//   --------+--------------------------+--------------------------------------
//   in      | in_valid_i / in_ready_o  | wind_tenths_i, moisture_tenths_i,
//           |                          | curing_tenths_i
//   out     | out_valid_o / out_ready_i| spread_index_hundredths_o, saturated_o
//
// One word enters per cycle while the output is not held; the pipeline is built
// from the 16-step log2, the 16-step power-of-two lanes and the 17-step divider.
// All stages advance together; when the output word is held, the whole
// pipeline holds and in_ready_o drops.
// Reset clears every valid bit; no clearing pass.
// ----------------------------------------------------------------------------
module grass_spread_index_calc_top import gsi_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [10:0] wind_tenths_i,
  input  logic [9:0]  moisture_tenths_i,
  input  logic [9:0]  curing_tenths_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [17:0] spread_index_hundredths_o,
  output logic        saturated_o
);

  logic        en;
  logic [10:0] d;
  gsi_ctx_t    ctx_in;

  logic        log_vld;
  logic [19:0] log_res;
  gsi_ctx_t    log_ctx;

  logic        exp_vld;
  logic [23:0] exp_p;
  logic [30:0] exp_e;
  gsi_ctx_t    exp_ctx;

  assign en         = !out_valid_o || out_ready_i;
  assign in_ready_o = en;

  assign d = (wind_tenths_i >= WIND_KNEE) ? wind_tenths_i - WIND_KNEE : 11'd1;

  always_comb begin
    ctx_in.wind  = wind_tenths_i;
    ctx_in.moist = moisture_tenths_i;
    ctx_in.cure  = curing_tenths_i;
  end

  gsi_log2_pipe u_log2 (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (in_valid_i),
    .d_i     (d),
    .ctx_i   (ctx_in),
    .valid_o (log_vld),
    .res_o   (log_res),
    .ctx_o   (log_ctx)
  );

  gsi_exp_pipe u_exp (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (log_vld),
    .res_i   (log_res),
    .ctx_i   (log_ctx),
    .valid_o (exp_vld),
    .p_o     (exp_p),
    .e_o     (exp_e),
    .ctx_o   (exp_ctx)
  );

  gsi_rate_pipe u_rate (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (exp_vld),
    .p_i     (exp_p),
    .e_i     (exp_e),
    .ctx_i   (exp_ctx),
    .valid_o (out_valid_o),
    .index_o (spread_index_hundredths_o),
    .sat_o   (saturated_o)
  );

endmodule

>>> hw/rtl/gsi_checker.sv
// ----------------------------------------------------------------------------
// Grass spread index port checker
// Watches the top-level ports for input hold, output hold, flow control and
// range.
// ----------------------------------------------------------------------------
module gsi_checker import gsi_pkg::*; (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_o,
  input logic [10:0] wind_tenths_i,
  input logic [9:0]  moisture_tenths_i,
  input logic [9:0]  curing_tenths_i,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [17:0] spread_index_hundredths_o,
  input logic        saturated_o
);

  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_ready_o |=> in_valid_i && $stable(wind_tenths_i)
      && $stable(moisture_tenths_i) && $stable(curing_tenths_i))
    else $error("input word changed while waiting");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(spread_index_hundredths_o)
      && $stable(saturated_o))
    else $error("output word changed while held");

  a_ready_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o)
    else $error("input stalled with empty output");

  a_sat_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && saturated_o |-> spread_index_hundredths_o == INDEX_MAX)
    else $error("saturated word not at maximum");

  a_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> spread_index_hundredths_o <= INDEX_MAX)
    else $error("index above maximum");

endmodule

bind grass_spread_index_calc_top gsi_checker u_gsi_checker (.*);
